// ----- hw/rtl/isw_blit_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isw_blit_pkg: shared types and constants of the scaled window blit
// Field widths, register indexes, the register file layout and reset values.
// ----------------------------------------------------------------------------
package isw_blit_pkg;

  localparam int PIXEL_W    = 8;
  localparam int OUT_ADDR_W = 20;
  localparam int POS_W      = 10;
  localparam int DEST_W     = 11;
  localparam int SCALE_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  // window offset times scale, plus destination origin
  localparam int BASE_W     = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_WIN_X      = 3'd1,
    CFG_WIN_Y      = 3'd2,
    CFG_WIN_WIDTH  = 3'd3,
    CFG_WIN_HEIGHT = 3'd4,
    CFG_DEST_X     = 3'd5,
    CFG_DEST_Y     = 3'd6,
    CFG_SCALE      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0]   src_width;
    logic [POS_W-1:0]   win_x;
    logic [POS_W-1:0]   win_y;
    logic [POS_W-1:0]   win_width;
    logic [POS_W-1:0]   win_height;
    logic [DEST_W-1:0]  dest_x;
    logic [DEST_W-1:0]  dest_y;
    logic [SCALE_W-1:0] scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    src_width:  10'd320,
    win_x:      10'd0,
    win_y:      10'd0,
    win_width:  10'd0,
    win_height: 10'd0,
    dest_x:     11'd0,
    dest_y:     11'd0,
    scale:      4'd1
  };

endpackage
`default_nettype wire

// ----- hw/rtl/integer_scaled_window_blit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_scaled_window_blit: nearest-neighbor integer upscale of a window
// Takes source bytes in raster order and emits scale x scale frame-buffer
// writes for every byte that falls inside the configured source window.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | in        | in_valid / in_stall  | in_pixel
//  out     | out       | out_valid / out_stall| out_address, out_color,
//          |           |                      | out_last_of_run
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
//  Rate: a pixel inside the window gives scale*scale writes, one write per
//  cycle while out_stall is low; one outside gives none. The write
//  generator sets the rate. Path: window stage, generator, output register.
//  Reset: synchronous, active low; a register write restarts the position.
//  Stalls: out_stall holds the output register; in_stall rises only while
//  the window stage holds a pixel that the generator cannot yet take.
//
module integer_scaled_window_blit #(
  parameter int LINE_PITCH = 640,
  parameter int MAX_SCALE  = 8,
  parameter int ADDR_BITS  = 20
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  // source pixel transactions
  input  wire                                      in_valid,
  output logic                                     in_stall,
  input  wire  [isw_blit_pkg::PIXEL_W-1:0]         in_pixel,
  // frame-buffer write transactions
  output logic                                     out_valid,
  input  wire                                      out_stall,
  output logic [isw_blit_pkg::OUT_ADDR_W-1:0]      out_address,
  output logic [isw_blit_pkg::PIXEL_W-1:0]         out_color,
  output logic                                     out_last_of_run,
  // register writes
  input  wire                                      cfg_we,
  input  wire  [isw_blit_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [isw_blit_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CNT_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int POS_W = isw_blit_pkg::POS_W;
  localparam int SW    = isw_blit_pkg::SCALE_W;
  localparam int BW    = isw_blit_pkg::BASE_W;

  // register file and source position
  isw_blit_pkg::cfg_t cfg_r, cfg_nxt;
  logic [POS_W-1:0]   col_r, col_nxt;
  logic [POS_W-1:0]   row_r, row_nxt;

  // window stage: one pixel known to be inside the window
  logic                             s1_v_r, s1_v_nxt;
  logic [isw_blit_pkg::PIXEL_W-1:0] s1_pixel_r, s1_pixel_nxt;
  logic [BW-1:0]                    s1_line_r, s1_line_nxt;
  logic [BW-1:0]                    s1_col_r, s1_col_nxt;

  // write generator
  logic                             g_busy_r, g_busy_nxt;
  logic [ADDR_BITS-1:0]             g_row_r, g_row_nxt;
  logic [CNT_W-1:0]                 g_n_r, g_n_nxt;
  logic [CNT_W-1:0]                 g_m_r, g_m_nxt;
  logic [isw_blit_pkg::PIXEL_W-1:0] g_color_r, g_color_nxt;

  // output register
  logic                                 out_valid_r, out_valid_nxt;
  logic [isw_blit_pkg::OUT_ADDR_W-1:0]  out_address_r, out_address_nxt;
  logic [isw_blit_pkg::PIXEL_W-1:0]     out_color_r, out_color_nxt;
  logic                                 out_last_r, out_last_nxt;

  logic [SW-1:0]        eff_scale;
  logic [SW-1:0]        s_m1;
  logic                 in_accept;
  logic                 hit;
  logic [POS_W-1:0]     rel_i;
  logic [POS_W-1:0]     rel_j;
  logic [POS_W:0]       col_inc;
  logic [POS_W:0]       win_x_end;
  logic [POS_W:0]       win_y_end;
  logic                 o_free;
  logic                 emit;
  logic                 n_end;
  logic                 g_last;
  logic                 g_done;
  logic                 g_free;
  logic                 load_g;
  logic [ADDR_BITS-1:0] row0;

  // Clamp the replication factor: zero acts as one, saturate at MAX_SCALE.
  always_comb begin
    if (cfg_r.scale == '0) begin
      eff_scale = SW'(1);
    end else if (cfg_r.scale > SW'(MAX_SCALE)) begin
      eff_scale = SW'(MAX_SCALE);
    end else begin
      eff_scale = cfg_r.scale;
    end
  end
  assign s_m1 = eff_scale - SW'(1);

  // Window test on the current position; the end bounds carry one extra bit.
  assign win_x_end = {1'b0, cfg_r.win_x} + {1'b0, cfg_r.win_width};
  assign win_y_end = {1'b0, cfg_r.win_y} + {1'b0, cfg_r.win_height};
  assign hit = (col_r >= cfg_r.win_x) && ({1'b0, col_r} < win_x_end) &&
               (row_r >= cfg_r.win_y) && ({1'b0, row_r} < win_y_end);
  assign rel_i = col_r - cfg_r.win_x;
  assign rel_j = row_r - cfg_r.win_y;
  assign col_inc = {1'b0, col_r} + (POS_W+1)'(1);

  // Handshake chain: output register, generator, window stage, input.
  assign o_free    = !out_valid_r || !out_stall;
  assign emit      = g_busy_r && o_free;
  assign n_end     = ({{(SW-CNT_W){1'b0}}, g_n_r} == s_m1);
  assign g_last    = n_end && ({{(SW-CNT_W){1'b0}}, g_m_r} == s_m1);
  assign g_done    = emit && g_last;
  assign g_free    = !g_busy_r || g_done;
  assign load_g    = s1_v_r && g_free;
  assign in_stall  = s1_v_r && !g_free;
  assign in_accept = in_valid && !in_stall;

  // First address of the run, reduced modulo 2^ADDR_BITS by the width.
  assign row0 = ADDR_BITS'(s1_line_r) * ADDR_BITS'(LINE_PITCH) + ADDR_BITS'(s1_col_r);

  always_comb begin
    cfg_nxt = cfg_r;
    col_nxt = col_r;
    row_nxt = row_r;

    // Register writes restart the raster position; unknown indexes drop.
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
      case (isw_blit_pkg::cfg_idx_t'(cfg_index))
        isw_blit_pkg::CFG_SRC_WIDTH:  cfg_nxt.src_width  = cfg_data[POS_W-1:0];
        isw_blit_pkg::CFG_WIN_X:      cfg_nxt.win_x      = cfg_data[POS_W-1:0];
        isw_blit_pkg::CFG_WIN_Y:      cfg_nxt.win_y      = cfg_data[POS_W-1:0];
        isw_blit_pkg::CFG_WIN_WIDTH:  cfg_nxt.win_width  = cfg_data[POS_W-1:0];
        isw_blit_pkg::CFG_WIN_HEIGHT: cfg_nxt.win_height = cfg_data[POS_W-1:0];
        isw_blit_pkg::CFG_DEST_X:     cfg_nxt.dest_x     = cfg_data;
        isw_blit_pkg::CFG_DEST_Y:     cfg_nxt.dest_y     = cfg_data;
        isw_blit_pkg::CFG_SCALE:      cfg_nxt.scale      = cfg_data[SW-1:0];
        default: begin
          col_nxt = col_r;
          row_nxt = row_r;
        end
      endcase
    end else if (in_accept) begin
      // Advance the column; wrap at the source width or at 1024.
      if ((col_inc == {1'b0, cfg_r.src_width}) || (col_inc[POS_W-1:0] == '0)) begin
        col_nxt = '0;
        row_nxt = row_r + POS_W'(1);
      end else begin
        col_nxt = col_inc[POS_W-1:0];
      end
    end
  end

  always_comb begin
    s1_v_nxt     = s1_v_r;
    s1_pixel_nxt = s1_pixel_r;
    s1_line_nxt  = s1_line_r;
    s1_col_nxt   = s1_col_r;
    if (in_accept && hit) begin
      // Hold only pixels that produce writes; the rest are dropped here.
      s1_v_nxt     = 1'b1;
      s1_pixel_nxt = in_pixel;
      s1_line_nxt  = BW'(cfg_r.dest_y) + BW'(rel_j) * BW'(eff_scale);
      s1_col_nxt   = BW'(cfg_r.dest_x) + BW'(rel_i) * BW'(eff_scale);
    end else if (load_g) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    g_busy_nxt  = g_busy_r;
    g_row_nxt   = g_row_r;
    g_n_nxt     = g_n_r;
    g_m_nxt     = g_m_r;
    g_color_nxt = g_color_r;
    if (load_g) begin
      g_busy_nxt  = 1'b1;
      g_row_nxt   = row0;
      g_n_nxt     = '0;
      g_m_nxt     = '0;
      g_color_nxt = s1_pixel_r;
    end else if (g_done) begin
      g_busy_nxt = 1'b0;
    end else if (emit) begin
      // Step across the run, then down one frame-buffer line.
      if (n_end) begin
        g_n_nxt   = '0;
        g_m_nxt   = g_m_r + CNT_W'(1);
        g_row_nxt = g_row_r + ADDR_BITS'(LINE_PITCH);
      end else begin
        g_n_nxt = g_n_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_address_nxt = out_address_r;
    out_color_nxt   = out_color_r;
    out_last_nxt    = out_last_r;
    if (emit) begin
      out_valid_nxt   = 1'b1;
      out_address_nxt = isw_blit_pkg::OUT_ADDR_W'(g_row_r + ADDR_BITS'(g_n_r));
      out_color_nxt   = g_color_r;
      out_last_nxt    = g_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= isw_blit_pkg::CFG_RESET;
      col_r       <= '0;
      row_r       <= '0;
      s1_v_r      <= 1'b0;
      g_busy_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_v_r      <= s1_v_nxt;
      g_busy_r    <= g_busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    s1_pixel_r    <= s1_pixel_nxt;
    s1_line_r     <= s1_line_nxt;
    s1_col_r      <= s1_col_nxt;
    g_row_r       <= g_row_nxt;
    g_n_r         <= g_n_nxt;
    g_m_r         <= g_m_nxt;
    g_color_r     <= g_color_nxt;
    out_address_r <= out_address_nxt;
    out_color_r   <= out_color_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_address     = out_address_r;
  assign out_color       = out_color_r;
  assign out_last_of_run = out_last_r;

  // The input side stalls only behind a held window-stage pixel.
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("input stalled with empty window stage");

  // Run counters stay inside the replication square.
  a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    g_busy_r |-> (({{(SW-CNT_W){1'b0}}, g_n_r} <= s_m1) &&
                  ({{(SW-CNT_W){1'b0}}, g_m_r} <= s_m1)))
    else $error("write generator counter beyond scale");

  // A new run starts only from a held window-stage pixel.
  a_run_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(g_busy_r) |-> $past(s1_v_r))
    else $error("write generator started without a pixel");

endmodule
`default_nettype wire

// ----- test/tb_integer_scaled_window_blit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_scaled_window_blit: self-checking bench for the scaled blit
// Streams source bytes through the block under varied window settings,
// predicts every frame-buffer write and compares the writes in order.
// ----------------------------------------------------------------------------
module tb_integer_scaled_window_blit;

  localparam int PIXEL_W    = isw_blit_pkg::PIXEL_W;
  localparam int OUT_ADDR_W = isw_blit_pkg::OUT_ADDR_W;
  localparam int POS_W      = isw_blit_pkg::POS_W;
  localparam int DEST_W     = isw_blit_pkg::DEST_W;
  localparam int SCALE_W    = isw_blit_pkg::SCALE_W;
  localparam int CFG_IDX_W  = isw_blit_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = isw_blit_pkg::CFG_DATA_W;

  localparam int LINE_PITCH     = 640;
  localparam int MAX_SCALE      = 8;
  localparam int ADDR_BITS      = 20;
  // quiet cycles after the last expected write before touching registers
  localparam int SETTLE_CYCLES  = 8;
  // long receiver hold-off that backs the block up into its input
  localparam int PRESSURE_HOLD  = 300;
  // cycles without any transaction before the run is declared hung
  localparam int WATCHDOG_LIMIT = 3000;
  // source bytes wanted over the whole run
  localparam int TOTAL_ITEMS    = 430;

  typedef enum int {
    PACE_STEADY,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_t;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] address;
    logic [PIXEL_W-1:0]    color;
    logic                  last_of_run;
  } fb_write_t;

  // Holds a private copy of the registers and the raster position, turns
  // each accepted source byte into its frame-buffer writes and checks the
  // writes that come out against them, oldest first.
  class fb_write_scoreboard;
    isw_blit_pkg::cfg_t regs;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    fb_write_t          expected_writes[$];
    int                 mismatches;

    function new();
      regs       = isw_blit_pkg::CFG_RESET;
      col        = '0;
      row        = '0;
      mismatches = 0;
    endfunction

    function void write_reg(isw_blit_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        isw_blit_pkg::CFG_SRC_WIDTH:  regs.src_width  = data[POS_W-1:0];
        isw_blit_pkg::CFG_WIN_X:      regs.win_x      = data[POS_W-1:0];
        isw_blit_pkg::CFG_WIN_Y:      regs.win_y      = data[POS_W-1:0];
        isw_blit_pkg::CFG_WIN_WIDTH:  regs.win_width  = data[POS_W-1:0];
        isw_blit_pkg::CFG_WIN_HEIGHT: regs.win_height = data[POS_W-1:0];
        isw_blit_pkg::CFG_DEST_X:     regs.dest_x     = data[DEST_W-1:0];
        isw_blit_pkg::CFG_DEST_Y:     regs.dest_y     = data[DEST_W-1:0];
        isw_blit_pkg::CFG_SCALE:      regs.scale      = data[SCALE_W-1:0];
        default:                      return;
      endcase
      // any register write restarts the raster
      col = '0;
      row = '0;
    endfunction

    // Queue the writes of one accepted source byte.
    function void take_pixel(logic [PIXEL_W-1:0] px);
      int                cx, ry, s;
      longint unsigned   addr;
      fb_write_t         w;
      cx = col;
      ry = row;
      s  = regs.scale;
      if (s == 0) s = 1;
      if (s > MAX_SCALE) s = MAX_SCALE;
      // window bounds are compared at full width, so a window may reach
      // past the last column or row without wrapping
      if (cx >= int'(regs.win_x) && cx < int'(regs.win_x) + int'(regs.win_width) &&
          ry >= int'(regs.win_y) && ry < int'(regs.win_y) + int'(regs.win_height)) begin
        for (int m = 0; m < s; m++) begin
          for (int n = 0; n < s; n++) begin
            addr = (longint'(regs.dest_y) + (ry - regs.win_y) * s + m) * LINE_PITCH
                   + regs.dest_x + (cx - regs.win_x) * s + n;
            addr &= (64'd1 << ADDR_BITS) - 1;
            w.address     = addr[OUT_ADDR_W-1:0];
            w.color       = px;
            w.last_of_run = (m == s - 1) && (n == s - 1);
            expected_writes.push_back(w);
          end
        end
      end
      // advance the raster; a zero source width runs the full column range
      if (cx + 1 == int'(regs.src_width) || cx + 1 == (1 << POS_W)) begin
        col = '0;
        row = row + 1'b1;
      end else begin
        col = col + 1'b1;
      end
    endfunction

    function void check_write(logic [OUT_ADDR_W-1:0] address,
                              logic [PIXEL_W-1:0] color,
                              logic last_of_run);
      fb_write_t want;
      if (expected_writes.size() == 0) begin
        $error("unexpected write: address %0h color %0h", address, color);
        mismatches++;
        return;
      end
      want = expected_writes.pop_front();
      if (address !== want.address) begin
        $error("address: expected %0h, got %0h", want.address, address);
        mismatches++;
      end
      if (color !== want.color) begin
        $error("color: expected %0h, got %0h", want.color, color);
        mismatches++;
      end
      if (last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", want.last_of_run, last_of_run);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return expected_writes.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIXEL_W-1:0]    in_pixel = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_ADDR_W-1:0] out_address;
  logic [PIXEL_W-1:0]    out_color;
  logic                  out_last_of_run;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fb_write_scoreboard fb_writes;
  pace_t              pace = PACE_STEADY;
  int                 sent_pixels = 0;
  // the stimulus bumps the request count; the receiver serves it
  int                 pressure_requests = 0;
  int                 pressure_served = 0;
  int                 hold_left = 0;
  int                 quiet_cycles = 0;

  integer_scaled_window_blit #(
    .LINE_PITCH(LINE_PITCH),
    .MAX_SCALE (MAX_SCALE),
    .ADDR_BITS (ADDR_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_address    (out_address),
    .out_color      (out_color),
    .out_last_of_run(out_last_of_run),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Receiver: check each accepted write transaction, then pick next stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        fb_writes.check_write(out_address, out_color, out_last_of_run);
      if (pressure_served != pressure_requests) begin
        hold_left       = PRESSURE_HOLD;
        pressure_served = pressure_requests;
      end
      if (hold_left > 0) begin
        // hold off entirely so the block fills and pushes back on its input
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (pace)
          PACE_RECEIVER_STALL: out_stall <= ($urandom_range(99) < 65);
          PACE_BOTH:           out_stall <= ($urandom_range(99) < 10);
          default:             out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Watchdog: end the run if no transaction of any kind moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one source byte, idling first as the pace asks; hold the payload
  // until the transaction is accepted, then hand the byte to the predictor.
  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    int idle_pct;
    case (pace)
      PACE_SENDER_IDLE: idle_pct = 65;
      PACE_BOTH:        idle_pct = 10;
      default:          idle_pct = 0;
    endcase
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (in_stall);
    fb_writes.take_pixel(px);
    sent_pixels++;
  endtask

  // Drop valid, wait for every predicted write, then let the pipe go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (fb_writes.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high so back-to-back writes never drop and raise it.
  task automatic write_reg(input isw_blit_pkg::cfg_idx_t idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    fb_writes.write_reg(idx, data);
  endtask

  // Write all eight registers; fill the unused high data bits with noise.
  task automatic program_blit(input isw_blit_pkg::cfg_t c);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(isw_blit_pkg::CFG_SRC_WIDTH,  {junk[CFG_DATA_W-1:POS_W], c.src_width});
    write_reg(isw_blit_pkg::CFG_WIN_X,      {junk[CFG_DATA_W-1:POS_W], c.win_x});
    write_reg(isw_blit_pkg::CFG_WIN_Y,      {junk[CFG_DATA_W-1:POS_W], c.win_y});
    write_reg(isw_blit_pkg::CFG_WIN_WIDTH,  {junk[CFG_DATA_W-1:POS_W], c.win_width});
    write_reg(isw_blit_pkg::CFG_WIN_HEIGHT, {junk[CFG_DATA_W-1:POS_W], c.win_height});
    write_reg(isw_blit_pkg::CFG_DEST_X,     c.dest_x);
    write_reg(isw_blit_pkg::CFG_DEST_Y,     c.dest_y);
    write_reg(isw_blit_pkg::CFG_SCALE,      {junk[CFG_DATA_W-1:SCALE_W], c.scale});
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    isw_blit_pkg::cfg_t c;
    int   sw;
    int   pick;
    int   count;
    fb_writes = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers give an empty window: these bytes must produce nothing.
    send_pixel(8'h00);
    send_pixel(8'hFF);
    settle();

    // Far corner destination wraps the address; scale zero acts as one.
    c = isw_blit_pkg::CFG_RESET;
    c.src_width  = 10'd4;
    c.win_width  = 10'd4;
    c.win_height = 10'd2;
    c.dest_x     = 11'd2047;
    c.dest_y     = 11'd2047;
    c.scale      = 4'd0;
    program_blit(c);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h5A);
    send_pixel(8'hA5);
    settle();

    // Scale above the maximum saturates; a single write also restarts the raster.
    write_reg(isw_blit_pkg::CFG_SCALE, 11'h7FF);
    cfg_we <= 1'b0;
    send_pixel(8'h3C);
    send_pixel(8'hC3);
    settle();

    // One-pixel-wide source: every byte starts a new row.
    c = isw_blit_pkg::CFG_RESET;
    c.src_width  = 10'd1;
    c.win_width  = 10'd1;
    c.win_height = 10'd3;
    c.dest_x     = 11'd5;
    c.dest_y     = 11'd1;
    c.scale      = 4'd2;
    program_blit(c);
    repeat (4) send_pixel(8'($urandom));
    settle();

    // Window offset inside the source on both axes.
    c = isw_blit_pkg::CFG_RESET;
    c.src_width  = 10'd4;
    c.win_x      = 10'd1;
    c.win_y      = 10'd1;
    c.win_width  = 10'd2;
    c.win_height = 10'd2;
    c.dest_x     = 11'd100;
    c.dest_y     = 11'd7;
    c.scale      = 4'd3;
    program_blit(c);
    repeat (12) send_pixel(8'($urandom));
    settle();

    // Zero source width: the column keeps counting instead of wrapping,
    // so a window beyond the first few columns is still reached.
    pace = PACE_BOTH;
    c = isw_blit_pkg::CFG_RESET;
    c.src_width  = 10'd0;
    c.win_x      = 10'd8;
    c.win_width  = 10'd4;
    c.win_height = 10'd2;
    c.dest_x     = 11'($urandom);
    c.dest_y     = 11'($urandom);
    c.scale      = 4'd2;
    program_blit(c);
    repeat (16) send_pixel(8'($urandom));
    settle();

    // Backpressure: stop the receiver long enough for the input to stall.
    pace = PACE_STEADY;
    c = isw_blit_pkg::CFG_RESET;
    c.src_width  = 10'd4;
    c.win_width  = 10'd4;
    c.win_height = 10'd2;
    c.dest_x     = 11'($urandom);
    c.dest_y     = 11'($urandom);
    c.scale      = 4'd8;
    program_blit(c);
    pressure_requests++;
    repeat (8) send_pixel(8'($urandom));
    settle();

    // Random settings, cycling through every pace, until enough bytes went in.
    for (int k = 0; sent_pixels < TOTAL_ITEMS; k++) begin
      pace = pace_t'(k % 4);
      sw   = $urandom_range(1, 12);
      c.src_width  = POS_W'(sw);
      c.win_x      = POS_W'($urandom_range(0, sw - 1));
      c.win_width  = POS_W'($urandom_range(1, sw - int'(c.win_x) + 1));
      c.win_y      = POS_W'($urandom_range(0, 2));
      c.win_height = POS_W'($urandom_range(1, 4));
      c.dest_x     = DEST_W'($urandom);
      c.dest_y     = DEST_W'($urandom);
      pick = $urandom_range(0, 9);
      case (pick)
        6:       c.scale = 4'd0;
        7:       c.scale = 4'd8;
        8:       c.scale = SCALE_W'($urandom_range(9, 15));
        9:       c.scale = SCALE_W'($urandom_range(4, 7));
        default: c.scale = SCALE_W'($urandom_range(1, 3));
      endcase
      program_blit(c);
      count = (int'(c.win_y) + int'(c.win_height)) * sw + $urandom_range(0, sw);
      repeat (count) send_pixel(8'($urandom));
      settle();
    end

    pace = PACE_STEADY;
    settle();
    if (fb_writes.mismatches == 0 && fb_writes.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
